FILE: rtl/hsvtco_pkg.sv
// shared types, register indexes, reset values and the bounds check for the hsv threshold and cross opening block
`timescale 1ns / 1ps

package hsvtco_pkg;

   localparam int CHAN_WIDTH      = 8;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int ROW_OUT_WIDTH   = 8;
   localparam int COL_OUT_WIDTH   = 7;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_HUE_LOW  = 3'd0,
      REG_SAT_LOW  = 3'd1,
      REG_VAL_LOW  = 3'd2,
      REG_HUE_HIGH = 3'd3,
      REG_SAT_HIGH = 3'd4,
      REG_VAL_HIGH = 3'd5
   } csr_index_type;

   localparam logic [CHAN_WIDTH-1:0] HUE_LOW_RESET  = 8'd59;
   localparam logic [CHAN_WIDTH-1:0] SAT_LOW_RESET  = 8'd23;
   localparam logic [CHAN_WIDTH-1:0] VAL_LOW_RESET  = 8'd64;
   localparam logic [CHAN_WIDTH-1:0] HUE_HIGH_RESET = 8'd180;
   localparam logic [CHAN_WIDTH-1:0] SAT_HIGH_RESET = 8'd255;
   localparam logic [CHAN_WIDTH-1:0] VAL_HIGH_RESET = 8'd255;

   typedef struct packed {
      logic [CHAN_WIDTH-1:0] hue_low;
      logic [CHAN_WIDTH-1:0] sat_low;
      logic [CHAN_WIDTH-1:0] val_low;
      logic [CHAN_WIDTH-1:0] hue_high;
      logic [CHAN_WIDTH-1:0] sat_high;
      logic [CHAN_WIDTH-1:0] val_high;
   } bounds_type;

   typedef struct packed {
      logic                     mask_bit;
      logic [ROW_OUT_WIDTH-1:0] out_row;
      logic [COL_OUT_WIDTH-1:0] out_col;
      logic                     frame_last;
   } result_type;

   function automatic logic in_bounds(
      input bounds_type            b,
      input logic [CHAN_WIDTH-1:0] h,
      input logic [CHAN_WIDTH-1:0] s,
      input logic [CHAN_WIDTH-1:0] v
   );
      return (h >= b.hue_low) && (h <= b.hue_high) &&
             (s >= b.sat_low) && (s <= b.sat_high) &&
             (v >= b.val_low) && (v <= b.val_high);
   endfunction

endpackage

FILE: rtl/hsvtco_cfg.sv
// threshold bound registers written through the csr port
`timescale 1ns / 1ps

module hsvtco_cfg
   import hsvtco_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CHAN_WIDTH-1:0]      csr_wdata,
   output bounds_type                 bounds
);

   bounds_type bounds_ff;
   bounds_type bounds_in;

   always_comb begin
      bounds_in = bounds_ff;
      if (csr_write) begin
         case (csr_index)
            REG_HUE_LOW:  bounds_in.hue_low  = csr_wdata;
            REG_SAT_LOW:  bounds_in.sat_low  = csr_wdata;
            REG_VAL_LOW:  bounds_in.val_low  = csr_wdata;
            REG_HUE_HIGH: bounds_in.hue_high = csr_wdata;
            REG_SAT_HIGH: bounds_in.sat_high = csr_wdata;
            REG_VAL_HIGH: bounds_in.val_high = csr_wdata;
            default:      bounds_in = bounds_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounds_ff.hue_low  <= HUE_LOW_RESET;
         bounds_ff.sat_low  <= SAT_LOW_RESET;
         bounds_ff.val_low  <= VAL_LOW_RESET;
         bounds_ff.hue_high <= HUE_HIGH_RESET;
         bounds_ff.sat_high <= SAT_HIGH_RESET;
         bounds_ff.val_high <= VAL_HIGH_RESET;
      end else begin
         bounds_ff <= bounds_in;
      end
   end

   assign bounds = bounds_ff;

endmodule

FILE: rtl/hsv_threshold_cross_opening.sv
// top level: hsv threshold, cross erosion and cross dilation over a raster stream
`timescale 1ns / 1ps

// Takes one pixel item per cycle while req_stall is low, thresholds it, and
// registers the opened mask bit of the pixel 2*COLS steps earlier as the item
// is accepted, in the output register or, while that is held, the skid stage.
// Two shift lines of 2*COLS bits hold the threshold and eroded history;
// every operator taps fixed places in them. After the last pixel of a frame,
// 2*COLS drain items flush the tail; a drain inside the frame body is taken
// and dropped, a pixel in the tail counts as a drain. An output register
// with a one-entry skid stage lets the block take the next item while a
// result waits; req_stall rises only when the skid stage is full.

module hsv_threshold_cross_opening
   import hsvtco_pkg::*;
#(
   parameter int ROWS = 160,
   parameter int COLS = 120
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CHAN_WIDTH-1:0]      req_hue,
   input  logic [CHAN_WIDTH-1:0]      req_saturation,
   input  logic [CHAN_WIDTH-1:0]      req_brightness,
   input  logic                       req_is_drain,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_mask_bit,
   output logic [ROW_OUT_WIDTH-1:0]   rsp_out_row,
   output logic [COL_OUT_WIDTH-1:0]   rsp_out_col,
   output logic                       rsp_frame_last,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CHAN_WIDTH-1:0]      csr_wdata
);

   localparam int RW   = $clog2(ROWS + 2);
   localparam int CW   = $clog2(COLS);
   localparam int LINE = 2 * COLS;

   localparam logic [RW-1:0] ROW_PIX  = RW'(ROWS);
   localparam logic [RW-1:0] ROW_LAST = RW'(ROWS + 1);
   localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

   bounds_type bounds;

   hsvtco_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .bounds    (bounds)
   );

   logic [RW-1:0]   in_row_ff, in_row_in;
   logic [CW-1:0]   in_col_ff, in_col_in;
   logic [LINE-1:0] thr_line_ff, thr_line_in;
   logic [LINE-1:0] ero_line_ff, ero_line_in;
   result_type      rsp_ff, rsp_in;
   result_type      skid_ff, skid_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            skid_valid_ff, skid_valid_in;

   logic            accept;
   logic            body;
   logic            step;
   logic            col_first;
   logic            col_last;
   logic            thr_bit;
   logic            ero_valid;
   logic            ero_bit;
   logic            dil_bit;
   logic            res_valid;
   logic            out_take;
   logic [RW-1:0]   res_row;
   logic [RW+ROW_OUT_WIDTH-1:0] res_row_ext;
   logic [CW+COL_OUT_WIDTH-1:0] res_col_ext;
   result_type      res;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign body      = in_row_ff < ROW_PIX;
   assign step      = accept && !(body && req_is_drain);
   assign col_first = in_col_ff == '0;
   assign col_last  = in_col_ff == COL_LAST;

   // threshold of the incoming pixel, zero in the frame tail
   assign thr_bit = body && in_bounds(bounds, req_hue, req_saturation, req_brightness);

   // erosion of the pixel one row back
   assign ero_valid = (in_row_ff != '0) && (in_row_ff <= ROW_PIX);
   assign ero_bit   = ero_valid && thr_line_ff[COLS-1] && thr_bit &&
                      (in_row_ff >= RW'(2)) && thr_line_ff[LINE-1] &&
                      !col_first && thr_line_ff[COLS] &&
                      !col_last && thr_line_ff[COLS-2];

   // dilation of the pixel two rows back
   assign dil_bit = ero_line_ff[COLS-1] || ero_bit ||
                    ((in_row_ff >= RW'(3)) && ero_line_ff[LINE-1]) ||
                    (!col_first && ero_line_ff[COLS]) ||
                    (!col_last && ero_line_ff[COLS-2]);

   assign res_valid   = step && (in_row_ff >= RW'(2));
   assign res_row     = in_row_ff - RW'(2);
   assign res_row_ext = {{ROW_OUT_WIDTH{1'b0}}, res_row};
   assign res_col_ext = {{COL_OUT_WIDTH{1'b0}}, in_col_ff};

   always_comb begin
      res.mask_bit   = dil_bit;
      res.out_row    = res_row_ext[ROW_OUT_WIDTH-1:0];
      res.out_col    = res_col_ext[COL_OUT_WIDTH-1:0];
      res.frame_last = (in_row_ff == ROW_LAST) && col_last;
   end

   // raster position and history lines
   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      thr_line_in = thr_line_ff;
      ero_line_in = ero_line_ff;
      if (step) begin
         thr_line_in = {thr_line_ff[LINE-2:0], thr_bit};
         ero_line_in = {ero_line_ff[LINE-2:0], ero_bit};
         if (col_last) begin
            in_col_in = '0;
            in_row_in = (in_row_ff == ROW_LAST) ? '0 : in_row_ff + RW'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
   end

   // output register with skid stage
   always_comb begin
      rsp_in        = rsp_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_take      = rsp_valid_ff && !rsp_stall;
      if (skid_valid_ff) begin
         if (out_take) begin
            rsp_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!rsp_valid_ff || out_take) begin
            rsp_in       = res;
            rsp_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff     <= '0;
         in_col_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         in_row_ff     <= in_row_in;
         in_col_ff     <= in_col_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      thr_line_ff <= thr_line_in;
      ero_line_ff <= ero_line_in;
      rsp_ff      <= rsp_in;
      skid_ff     <= skid_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_mask_bit   = rsp_ff.mask_bit;
   assign rsp_out_row    = rsp_ff.out_row;
   assign rsp_out_col    = rsp_ff.out_col;
   assign rsp_frame_last = rsp_ff.frame_last;

   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage holds an item while the output register is empty");

   a_position_range : assert property (@(posedge clock) disable iff (reset)
      (in_col_ff <= COL_LAST) && (in_row_ff <= ROW_LAST))
      else $error("raster position outside the frame step range");

   a_frame_wrap : assert property (@(posedge clock) disable iff (reset)
      (step && col_last && (in_row_ff == ROW_LAST)) |=> ((in_row_ff == '0) && (in_col_ff == '0)))
      else $error("position did not return to the frame start after the last tail step");

   a_no_result_on_ignored : assert property (@(posedge clock) disable iff (reset)
      (!step && !skid_valid_ff && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result appeared without a counted step");

endmodule

FILE: verif/hsvtco_checker.sv
// checker for the hsv threshold and cross opening block: predicts each opened mask bit and compares
`timescale 1ns / 1ps

module hsvtco_checker
   import hsvtco_pkg::*;
#(
   parameter int ROWS = 160,
   parameter int COLS = 120
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [CHAN_WIDTH-1:0]      req_hue,
   input  logic [CHAN_WIDTH-1:0]      req_saturation,
   input  logic [CHAN_WIDTH-1:0]      req_brightness,
   input  logic                       req_is_drain,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic                       rsp_mask_bit,
   input  logic [ROW_OUT_WIDTH-1:0]   rsp_out_row,
   input  logic [COL_OUT_WIDTH-1:0]   rsp_out_col,
   input  logic                       rsp_frame_last,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CHAN_WIDTH-1:0]      csr_wdata,
   output int                         fail_count,
   output int                         pending_count,
   output int                         checked_count,
   output int                         frame_ends
);

   localparam int PIXELS      = ROWS * COLS;
   localparam int HIST        = 2 * COLS + 1;
   localparam int FRAME_STEPS = PIXELS + 2 * COLS;

   bounds_type      bounds;
   logic [HIST-1:0] thr_line;
   logic [HIST-1:0] ero_line;
   int              step_pos;
   int              report_pos;
   result_type      opened_q[$];
   int              fails;
   int              checked;
   int              ends;

   // out-of-frame pixels read as 0
   function automatic logic line_bit(input logic [HIST-1:0] line, input int q);
      if (q < 0 || q >= PIXELS)
         return 1'b0;
      return line[q % HIST];
   endfunction

   function automatic logic cross_reduce(input logic [HIST-1:0] line, input int q,
                                         input logic erode);
      int         c;
      logic [4:0] n;
      c = q % COLS;
      n[0] = line_bit(line, q);
      n[1] = line_bit(line, q - COLS);
      n[2] = line_bit(line, q + COLS);
      n[3] = (c > 0) ? line_bit(line, q - 1) : 1'b0;
      n[4] = (c < COLS - 1) ? line_bit(line, q + 1) : 1'b0;
      return erode ? &n : |n;
   endfunction

   task automatic advance_window(input logic [CHAN_WIDTH-1:0] h, s, v, input logic drain);
      int          e;
      logic [31:0] pos;
      result_type  r;
      // a drain inside the frame body is dropped
      if (step_pos >= PIXELS || !drain) begin
         e = step_pos - COLS;
         if (step_pos < PIXELS)
            thr_line[step_pos % HIST] = (h >= bounds.hue_low) && (h <= bounds.hue_high) &&
                                        (s >= bounds.sat_low) && (s <= bounds.sat_high) &&
                                        (v >= bounds.val_low) && (v <= bounds.val_high);
         if (e >= 0 && e < PIXELS)
            ero_line[e % HIST] = cross_reduce(thr_line, e, 1'b1);
         if (step_pos >= 2 * COLS) begin
            if (report_pos < PIXELS) begin
               r.mask_bit = cross_reduce(ero_line, report_pos, 1'b0);
               pos = report_pos / COLS;
               r.out_row = pos[ROW_OUT_WIDTH-1:0];
               pos = report_pos % COLS;
               r.out_col = pos[COL_OUT_WIDTH-1:0];
               r.frame_last = (report_pos == PIXELS - 1);
               opened_q.push_back(r);
            end
            report_pos++;
         end
         step_pos++;
         if (step_pos >= FRAME_STEPS) begin
            step_pos = 0;
            report_pos = 0;
         end
      end
   endtask

   task automatic compare_result;
      result_type want;
      if (opened_q.size() == 0) begin
         fails++;
         if (fails <= 10)
            $display("opening_check: result with nothing pending, mask %0b row %0d col %0d last %0b",
                     rsp_mask_bit, rsp_out_row, rsp_out_col, rsp_frame_last);
      end else begin
         want = opened_q.pop_front();
         checked++;
         if (want.frame_last)
            ends++;
         if (rsp_mask_bit !== want.mask_bit || rsp_out_row !== want.out_row ||
             rsp_out_col !== want.out_col || rsp_frame_last !== want.frame_last) begin
            fails++;
            if (fails <= 10)
               $display("opening_check: mismatch, expected mask %0b row %0d col %0d last %0b, %s",
                        want.mask_bit, want.out_row, want.out_col, want.frame_last,
                        $sformatf("got mask %0b row %0d col %0d last %0b", rsp_mask_bit,
                                  rsp_out_row, rsp_out_col, rsp_frame_last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bounds.hue_low = HUE_LOW_RESET;
         bounds.sat_low = SAT_LOW_RESET;
         bounds.val_low = VAL_LOW_RESET;
         bounds.hue_high = HUE_HIGH_RESET;
         bounds.sat_high = SAT_HIGH_RESET;
         bounds.val_high = VAL_HIGH_RESET;
         thr_line = '0;
         ero_line = '0;
         step_pos = 0;
         report_pos = 0;
         opened_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            compare_result();
         if (req_valid && !req_stall)
            advance_window(req_hue, req_saturation, req_brightness, req_is_drain);
         if (csr_write) begin
            case (csr_index)
               REG_HUE_LOW:  bounds.hue_low = csr_wdata;
               REG_SAT_LOW:  bounds.sat_low = csr_wdata;
               REG_VAL_LOW:  bounds.val_low = csr_wdata;
               REG_HUE_HIGH: bounds.hue_high = csr_wdata;
               REG_SAT_HIGH: bounds.sat_high = csr_wdata;
               REG_VAL_HIGH: bounds.val_high = csr_wdata;
               default: ;
            endcase
         end
      end
      fail_count <= fails;
      pending_count <= opened_q.size();
      checked_count <= checked;
      frame_ends <= ends;
   end

endmodule

FILE: verif/tb_top.sv
// testbench top: clock, reset, stimulus, bound settings and verdict for the threshold and opening block
`timescale 1ns / 1ps

module tb_top;
   import hsvtco_pkg::*;

   localparam int FRAME_ROWS   = 160;
   localparam int FRAME_COLS   = 120;
   localparam int PIXELS       = FRAME_ROWS * FRAME_COLS;
   localparam int FRAME_STEPS  = PIXELS + 2 * FRAME_COLS;
   localparam int RANDOM_ITEMS = 1150;
   localparam int CYCLE_LIMIT  = 1500000;
   localparam int LONG_HOLD    = 400;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_LOW  = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SPARE_HIGH = 3'd7;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [CHAN_WIDTH-1:0]      req_hue;
   logic [CHAN_WIDTH-1:0]      req_saturation;
   logic [CHAN_WIDTH-1:0]      req_brightness;
   logic                       req_is_drain;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_mask_bit;
   logic [ROW_OUT_WIDTH-1:0]   rsp_out_row;
   logic [COL_OUT_WIDTH-1:0]   rsp_out_col;
   logic                       rsp_frame_last;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CHAN_WIDTH-1:0]      csr_wdata;

   int fail_count;
   int pending_count;
   int checked_count;
   int frame_ends;
   int cycle_count;

   logic [CHAN_WIDTH-1:0] bound_val [0:5];
   logic                  send_quiet;
   logic                  rsp_quiet;
   int                    hold_request;
   int                    frame_step;
   int                    frames_done;
   int                    pixel_items;
   int                    drain_items;
   int                    settings_used;
   int                    density;
   logic                  above_class [0:FRAME_COLS-1];
   logic                  left_class;

   hsv_threshold_cross_opening #(.ROWS(FRAME_ROWS), .COLS(FRAME_COLS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_hue(req_hue),
      .req_saturation(req_saturation), .req_brightness(req_brightness),
      .req_is_drain(req_is_drain),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_mask_bit(rsp_mask_bit),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col), .rsp_frame_last(rsp_frame_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   hsvtco_checker #(.ROWS(FRAME_ROWS), .COLS(FRAME_COLS)) opening_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_hue(req_hue),
      .req_saturation(req_saturation), .req_brightness(req_brightness),
      .req_is_drain(req_is_drain),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_mask_bit(rsp_mask_bit),
      .rsp_out_row(rsp_out_row), .rsp_out_col(rsp_out_col), .rsp_frame_last(rsp_frame_last),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count),
      .checked_count(checked_count), .frame_ends(frame_ends)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // receiver: stall drawn after every item taken, or one long hold when asked
   initial begin : receiver
      int   stall_left;
      logic took;
      stall_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         took = rsp_valid && !rsp_stall && !reset;
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left = hold_request;
            hold_request = 0;
         end else if (took) begin
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 8);
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0)
            stall_left--;
      end
   end

   function automatic logic [CHAN_WIDTH-1:0] pick_inside(input int lo, input int hi);
      if (lo <= hi)
         return CHAN_WIDTH'($urandom_range(hi, lo));
      return CHAN_WIDTH'($urandom_range(255, 0));
   endfunction

   task automatic make_pixel(input logic want, output logic [CHAN_WIDTH-1:0] h, s, v);
      logic [CHAN_WIDTH-1:0] chan [0:2];
      int                    k;
      int                    lo;
      int                    hi;
      for (k = 0; k < 3; k++)
         chan[k] = pick_inside(int'(bound_val[int'(REG_HUE_LOW) + k]),
                               int'(bound_val[int'(REG_HUE_HIGH) + k]));
      if (!want) begin
         k = $urandom_range(0, 2);
         lo = int'(bound_val[int'(REG_HUE_LOW) + k]);
         hi = int'(bound_val[int'(REG_HUE_HIGH) + k]);
         if (lo > 0 && (hi == 255 || $urandom_range(0, 1) == 0))
            chan[k] = CHAN_WIDTH'($urandom_range(lo - 1, 0));
         else if (hi < 255)
            chan[k] = CHAN_WIDTH'($urandom_range(255, hi + 1));
      end
      // occasional noise pixel
      if ($urandom_range(0, 11) == 0) begin
         for (k = 0; k < 3; k++)
            chan[k] = CHAN_WIDTH'($urandom_range(255, 0));
      end
      h = chan[0];
      s = chan[1];
      v = chan[2];
   endtask

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic offer_item(input logic [CHAN_WIDTH-1:0] h, s, v, input logic drain);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 8);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_hue <= h;
      req_saturation <= s;
      req_brightness <= v;
      req_is_drain <= drain;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      if (drain)
         drain_items++;
      else
         pixel_items++;
      if (frame_step >= PIXELS || !drain) begin
         frame_step++;
         if (frame_step >= FRAME_STEPS) begin
            frame_step = 0;
            frames_done++;
         end
      end
   endtask

   task automatic send_shaped_item;
      logic                  want;
      logic [CHAN_WIDTH-1:0] h;
      logic [CHAN_WIDTH-1:0] s;
      logic [CHAN_WIDTH-1:0] v;
      int                    col;
      int                    pick;
      if (frame_step >= PIXELS) begin
         // frame tail: mostly drains, some pixels that only count as drains
         make_pixel($urandom_range(0, 1) == 1, h, s, v);
         offer_item(h, s, v, $urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 29) == 0) begin
         offer_item(CHAN_WIDTH'($urandom_range(255, 0)), CHAN_WIDTH'($urandom_range(255, 0)),
                    CHAN_WIDTH'($urandom_range(255, 0)), 1'b1);
      end else begin
         // blobs: copy the class from above or the left most of the time
         col = frame_step % FRAME_COLS;
         pick = $urandom_range(0, 99);
         if (pick < 70 && frame_step >= FRAME_COLS)
            want = above_class[col];
         else if (pick < 85 && col > 0)
            want = left_class;
         else
            want = ($urandom_range(0, 99) < density);
         above_class[col] = want;
         left_class = want;
         make_pixel(want, h, s, v);
         offer_item(h, s, v, 1'b0);
      end
   endtask

   task automatic choose_bounds(input int seg);
      int style;
      int k;
      int a;
      int b;
      int lo;
      int hi;
      style = (seg <= 4) ? seg : $urandom_range(1, 7);
      for (k = 0; k < 3; k++) begin
         a = $urandom_range(0, 255);
         b = $urandom_range(0, 255);
         case (style)
            1: begin
               lo = 0;
               hi = 255;
            end
            2: begin
               // reversed on hue only
               lo = (k == 0) ? ((a > b) ? a : 255) : 0;
               hi = (k == 0) ? ((a > b) ? b : 0) : 255;
            end
            3: begin
               lo = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) == 0) ? 255 : a);
               hi = lo;
            end
            5: begin
               lo = a;
               hi = b;
            end
            default: begin
               lo = (a < b) ? a : b;
               hi = (a < b) ? b : a;
            end
         endcase
         bound_val[int'(REG_HUE_LOW) + k] = CHAN_WIDTH'(lo);
         bound_val[int'(REG_HUE_HIGH) + k] = CHAN_WIDTH'(hi);
      end
      if (style == 0) begin
         bound_val[REG_HUE_LOW] = HUE_LOW_RESET;
         bound_val[REG_SAT_LOW] = SAT_LOW_RESET;
         bound_val[REG_VAL_LOW] = VAL_LOW_RESET;
         bound_val[REG_HUE_HIGH] = HUE_HIGH_RESET;
         bound_val[REG_SAT_HIGH] = SAT_HIGH_RESET;
         bound_val[REG_VAL_HIGH] = VAL_HIGH_RESET;
      end
   endtask

   // called at a falling edge with the block idle
   task automatic load_bounds;
      int r;
      for (r = int'(REG_HUE_LOW); r <= int'(REG_VAL_HIGH); r++) begin
         csr_write <= 1'b1;
         csr_index <= CSR_INDEX_WIDTH'(r);
         csr_wdata <= bound_val[r];
         @(negedge clock);
      end
      // unused indexes must leave the bounds alone
      csr_index <= ($urandom_range(0, 1) == 0) ? REG_SPARE_LOW : REG_SPARE_HIGH;
      csr_wdata <= CHAN_WIDTH'($urandom_range(255, 0));
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain_block;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0)
         @(posedge clock);
      repeat (4)
         @(posedge clock);
   endtask

   initial begin : stimulus
      int   seg;
      int   n;
      int   seg_len;
      int   k;
      logic finished;
      reset = 1'b1;
      req_valid = 1'b0;
      req_hue = '0;
      req_saturation = '0;
      req_brightness = '0;
      req_is_drain = 1'b0;
      csr_write = 1'b0;
      csr_index = REG_HUE_LOW;
      csr_wdata = '0;
      send_quiet = 1'b0;
      rsp_quiet = 1'b0;
      hold_request = 0;
      density = 50;
      left_class = 1'b0;
      for (k = 0; k < FRAME_COLS; k++)
         above_class[k] = 1'b0;
      bound_val[REG_HUE_LOW] = HUE_LOW_RESET;
      bound_val[REG_SAT_LOW] = SAT_LOW_RESET;
      bound_val[REG_VAL_LOW] = VAL_LOW_RESET;
      bound_val[REG_HUE_HIGH] = HUE_HIGH_RESET;
      bound_val[REG_SAT_HIGH] = SAT_HIGH_RESET;
      bound_val[REG_VAL_HIGH] = VAL_HIGH_RESET;
      repeat (12)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // channel extremes and the edges of the reset bounds
      offer_item(8'd0, 8'd0, 8'd0, 1'b0);
      offer_item(8'd255, 8'd255, 8'd255, 1'b0);
      offer_item(HUE_LOW_RESET, SAT_LOW_RESET, VAL_LOW_RESET, 1'b0);
      offer_item(HUE_LOW_RESET - 8'd1, SAT_LOW_RESET, VAL_LOW_RESET, 1'b0);
      offer_item(HUE_HIGH_RESET, SAT_HIGH_RESET, VAL_HIGH_RESET, 1'b0);
      offer_item(HUE_HIGH_RESET + 8'd1, 8'd128, 8'd128, 1'b0);
      offer_item(8'd100, SAT_LOW_RESET - 8'd1, 8'd100, 1'b0);
      offer_item(8'd100, 8'd100, VAL_LOW_RESET - 8'd1, 1'b0);
      offer_item(8'hAA, 8'h55, 8'hAA, 1'b0);
      offer_item(8'h55, 8'hAA, 8'h55, 1'b0);
      // drains inside the frame body are dropped
      offer_item(8'd255, 8'd255, 8'd255, 1'b1);
      offer_item(8'd0, 8'd0, 8'd0, 1'b1);
      repeat (12)
         offer_item(8'd120, 8'd128, 8'd200, 1'b0);

      seg = 0;
      finished = 1'b0;
      while (!finished) begin
         drain_block();
         choose_bounds(seg);
         send_quiet = (seg == 3) || ($urandom_range(0, 2) == 0);
         rsp_quiet = ($urandom_range(0, 2) == 0);
         if (seg == 3)
            hold_request = LONG_HOLD;
         case ($urandom_range(0, 2))
            0: density = 10;
            1: density = 50;
            default: density = 90;
         endcase
         @(negedge clock);
         load_bounds();
         seg_len = $urandom_range(80, 250);
         n = 0;
         while (n < seg_len && !finished) begin
            send_shaped_item();
            n++;
            finished = (pixel_items + drain_items >= RANDOM_ITEMS);
         end
         settings_used++;
         seg++;
      end

      drain_block();
      repeat (8)
         @(posedge clock);
      $display("tb_top: %0d pixel and %0d drain items over %0d bound settings",
               pixel_items, drain_items, settings_used);
      $display("tb_top: %0d opened mask bits compared, %0d frame ends seen",
               checked_count, frame_ends);
      if (fail_count == 0 && pending_count == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
